// ===== rtl/ccm_pkg.sv =====
package ccm_pkg;

  // Access codes carried by the action field.
  localparam logic [1:0] ACT_READ_DIP    = 2'd0;
  localparam logic [1:0] ACT_READ_CREDIT = 2'd1;
  localparam logic [1:0] ACT_COIN_QUERY  = 2'd2;
  localparam logic [1:0] ACT_OTHER       = 2'd3;

  // Register index of the dip switch byte.
  localparam logic REG_DIP_SWITCHES = 1'b0;

  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam int unsigned CREDIT_W = 3;

  localparam logic [7:0] STATUS_BYTE = 8'h22;

  // Coinage table, indexed by the inverted dip bit 3.
  localparam logic [7:0]          NEED_A  [2] = '{8'd1, 8'd1};
  localparam logic [CREDIT_W-1:0] AWARD_A [2] = '{3'd1, 3'd2};
  localparam logic [7:0]          NEED_B  [2] = '{8'd1, 8'd2};
  localparam logic [CREDIT_W-1:0] AWARD_B [2] = '{3'd5, 3'd1};

  typedef struct packed {
    logic [1:0] action;
    logic       coin_a;
    logic       coin_b;
  } item_t;

  typedef struct packed {
    logic                mailbox_write;
    logic [7:0]          mailbox_value;
    logic                status_write;
    logic [7:0]          status_value;
    logic [CREDIT_W-1:0] credit_value;
  } result_t;

endpackage

// ===== rtl/ccm_item_if.sv =====
interface ccm_item_if;
  import ccm_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       coin_a;
  logic       coin_b;

  modport source (output valid, output action, output coin_a, output coin_b, input ready);
  modport sink   (input valid, input action, input coin_a, input coin_b, output ready);
endinterface

// ===== rtl/ccm_result_if.sv =====
interface ccm_result_if;
  import ccm_pkg::*;

  logic                valid;
  logic                ready;
  logic                mailbox_write;
  logic [7:0]          mailbox_value;
  logic                status_write;
  logic [7:0]          status_value;
  logic [CREDIT_W-1:0] credit_value;

  modport source (output valid, output mailbox_write, output mailbox_value,
                  output status_write, output status_value, output credit_value,
                  input ready);
  modport sink   (input valid, input mailbox_write, input mailbox_value,
                  input status_write, input status_value, input credit_value,
                  output ready);
endinterface

// ===== rtl/coin_credit_mcu_top.sv =====
// Coin credit controller.
// The item channel carries one processor access word: the action code and
// the current levels of the two coin switches. The result channel returns
// one word per access: the mailbox write and value, the status write and
// value, and the credit count held after the access.
// The dip switch byte is written through the APB-style port at any address
// with bit 2 clear (0 to 3) and can be read back there.
// A word accepted at a clock edge is registered and presented on the result
// channel in the next cycle. Throughput is one word per cycle while the
// receiver takes each word; the figure is set by the single result register,
// which is refilled in the same cycle in which its word is taken.
// When the receiver stalls, the result register holds its word and the
// item channel drops ready until the result is taken.
// Reset (synchronous, active high) clears the insert latch, both deposit
// counters, the credit count, the dip byte and the result valid flag.
module coin_credit_mcu_top (
  input  logic                          clk,
  input  logic                          rst,
  ccm_item_if.sink                      item,
  ccm_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ccm_pkg::PADDR_W-1:0]   paddr,
  input  logic [ccm_pkg::PDATA_W-1:0]   pwdata,
  output logic [ccm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import ccm_pkg::*;

  logic [7:0]          dip_switches;
  logic                insert_latch;
  logic                insert_latch_next;
  logic [7:0]          deposits_slot_a;
  logic [7:0]          deposits_slot_a_next;
  logic [7:0]          deposits_slot_b;
  logic [7:0]          deposits_slot_b_next;
  logic [CREDIT_W-1:0] credit_count;
  logic [CREDIT_W-1:0] credit_count_next;
  result_t             res;
  result_t             res_next;
  logic                res_valid;
  logic                accept;
  logic                row;
  logic [7:0]          inc_a;
  logic [7:0]          inc_b;

  // Configuration port: zero wait states, one register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DIP_SWITCHES) ? {{(PDATA_W-8){1'b0}}, dip_switches}
                                                 : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dip_switches <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DIP_SWITCHES)) begin
      dip_switches <= pwdata[7:0];
    end
  end

  // A new word enters whenever the result register is free or being emptied.
  assign item.ready = !res_valid || result.ready;
  assign accept     = item.valid && item.ready;

  assign row   = ~dip_switches[3];
  assign inc_a = deposits_slot_a + 8'd1;
  assign inc_b = deposits_slot_b + 8'd1;

  // Access decode and coin counting.
  always_comb begin
    insert_latch_next    = insert_latch;
    deposits_slot_a_next = deposits_slot_a;
    deposits_slot_b_next = deposits_slot_b;
    credit_count_next    = credit_count;
    res_next             = '0;
    unique case (item.action)
      ACT_READ_DIP: begin
        res_next.mailbox_write = 1'b1;
        res_next.mailbox_value = dip_switches;
      end
      ACT_READ_CREDIT: begin
        res_next.mailbox_write = 1'b1;
        res_next.mailbox_value = {{(8-CREDIT_W){1'b0}}, credit_count};
      end
      ACT_COIN_QUERY: begin
        credit_count_next     = '0;
        res_next.status_write = 1'b1;
        res_next.status_value = STATUS_BYTE;
        if (!item.coin_a && !item.coin_b) begin
          insert_latch_next = 1'b0;
        end else if (!insert_latch) begin
          // Fresh insert; coin A wins when both switches are closed.
          insert_latch_next      = 1'b1;
          res_next.mailbox_write = 1'b1;
          if (item.coin_a) begin
            if (inc_a == NEED_A[row]) begin
              credit_count_next    = AWARD_A[row];
              deposits_slot_a_next = '0;
            end else begin
              deposits_slot_a_next = inc_a;
            end
          end else begin
            if (inc_b == NEED_B[row]) begin
              credit_count_next    = AWARD_B[row];
              deposits_slot_b_next = '0;
            end else begin
              deposits_slot_b_next = inc_b;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res_next.credit_value = credit_count_next;
  end

  // State update on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      insert_latch    <= 1'b0;
      deposits_slot_a <= '0;
      deposits_slot_b <= '0;
      credit_count    <= '0;
    end else if (accept) begin
      insert_latch    <= insert_latch_next;
      deposits_slot_a <= deposits_slot_a_next;
      deposits_slot_b <= deposits_slot_b_next;
      credit_count    <= credit_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.mailbox_write = res.mailbox_write;
  assign result.mailbox_value = res.mailbox_value;
  assign result.status_write  = res.status_write;
  assign result.status_value  = res.status_value;
  assign result.credit_value  = res.credit_value;

  // The presented credit value is the credit count left by the last access.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (result.credit_value == credit_count))
    else $error("result credit does not match the stored credit count");

  // An access to another offset leaves all counting state alone.
  assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_OTHER) |=>
      ($stable(credit_count) && $stable(deposits_slot_a) &&
       $stable(deposits_slot_b) && $stable(insert_latch)))
    else $error("other offset changed the coin state");

  // A query with no coin present releases the insert latch.
  assert property (@(posedge clk) disable iff (rst)
    (accept && item.action == ACT_COIN_QUERY && !item.coin_a && !item.coin_b) |=>
      !insert_latch)
    else $error("insert latch not released");

  // A stalled result is not overwritten.
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(res)))
    else $error("stalled result changed");

  // Credits only grow through a coin query that counts a fresh coin.
  assert property (@(posedge clk) disable iff (rst)
    (credit_count != $past(credit_count) && credit_count != '0) |->
      ($past(accept) && $past(item.action) == ACT_COIN_QUERY && !$past(insert_latch))
  ) else $error("credits awarded outside a fresh insert");

endmodule
